>>> rtl/pipw_pkg.sv
`default_nettype none

package pipw_pkg;

  localparam int COORD_W      = 16;
  localparam int MAX_VERTICES = 64;
  localparam int WIND_W       = 7;
  localparam int PC_W         = 3;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic signed [WIND_W-1:0] winding;
    logic                     inside_res;
    logic                     overflowed;
  } out_word_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_QUERY,
    COND_COUNT_ZERO,
    COND_IDX_LT,
    COND_OUT_BUSY
  } cond_t;

  // One microinstruction: datapath strobes, jump condition and jump target.
  typedef struct packed {
    logic            ready;
    logic            rd_first;
    logic            rd_loop;
    logic            inject;
    logic            result;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_QSTART = 3'd1;
  localparam logic [PC_W-1:0] PC_LOOP   = 3'd2;
  localparam logic [PC_W-1:0] PC_CLOSE  = 3'd3;
  localparam logic [PC_W-1:0] PC_RESULT = 3'd7;

  // The program. A false condition falls through to the next step; the result
  // step is last, so falling through from it wraps back to idle.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    u = '{ready: 1'b0, rd_first: 1'b0, rd_loop: 1'b0, inject: 1'b0, result: 1'b0,
          cond: COND_NONE, target: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        u.ready  = 1'b1;
        u.cond   = COND_NO_QUERY;
        u.target = PC_IDLE;
      end
      PC_QSTART: begin
        u.rd_first = 1'b1;
        u.cond     = COND_COUNT_ZERO;
        u.target   = PC_RESULT;
      end
      PC_LOOP: begin
        u.rd_loop = 1'b1;
        u.cond    = COND_IDX_LT;
        u.target  = PC_LOOP;
      end
      PC_CLOSE: begin
        u.inject = 1'b1;
      end
      PC_RESULT: begin
        u.result = 1'b1;
        u.cond   = COND_OUT_BUSY;
        u.target = PC_RESULT;
      end
      default: begin
        // drain steps: let the last edges reach the accumulator
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

>>> rtl/point_in_polygon_winding.sv
`default_nettype none

// Channel  Direction  Payload     Handshake
// in       input      in_word_t   in_valid / in_ready
// out      output     out_word_t  out_valid / out_ready
//
// Start and append words are accepted while idle and written straight into
// the vertex memory. A query holds the input through the accepting step, the
// first read, one step per vertex, the closing edge, three steps while the
// last edges pass the pipeline (differences, products, compare and count)
// and the result step; with none stored, the first read jumps to the result.
// One step per vertex follows from the single read port of the vertex memory.
// Reset clears the sequencer, vertex count and overflow flag; no memory sweep.
// A finished result waits in the output register while new words are taken;
// the next result step holds until that register has been emptied.
module point_in_polygon_winding
  import pipw_pkg::*;
#(
  parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DW    = COORD_W + 1;
  localparam int PW    = 2 * DW;
  localparam int XW    = PW + 1;
  localparam int VW    = 2 * COORD_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

  // sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          uc;

  // vertex store and bookkeeping
  logic [VW-1:0]    mem [MAX_VERTICES];
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [CNT_W-1:0] idx;

  logic             accept;
  logic             acc_query;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [VW-1:0]    rdata;
  logic             rv;
  logic             rfirst;
  logic             idx_lt;
  logic             out_busy;
  logic             cond_true;

  // query point and edge end points
  logic signed [COORD_W-1:0] px, py;
  logic signed [COORD_W-1:0] first_x, first_y;
  logic signed [COORD_W-1:0] prev_x, prev_y;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic                      edge_v;

  // pipeline
  logic                 bv, bup, bdn;
  logic signed [DW-1:0] ba, bb, bc, bd;
  logic                 cv, cup, cdn;
  logic signed [PW-1:0] cp1, cp2;
  logic signed [XW-1:0] cross_prod;
  logic [WIND_W-1:0]    acc;

  assign uc        = ucode_rom(pc);
  assign in_ready  = uc.ready;
  assign accept    = in_valid && in_ready;
  assign acc_query = accept && (in_word.operation == OP_QUERY);
  assign idx_lt    = idx < count;
  assign out_busy  = out_valid && !out_ready;

  always_comb begin
    case (uc.cond)
      COND_NO_QUERY:   cond_true = !acc_query;
      COND_COUNT_ZERO: cond_true = (count == '0);
      COND_IDX_LT:     cond_true = idx_lt;
      COND_OUT_BUSY:   cond_true = out_busy;
      default:         cond_true = 1'b0;
    endcase
    pc_next = cond_true ? uc.target : pc + PC_W'(1);
  end

  // Write side: start rewrites entry zero, append goes to the next free entry.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    if (accept) begin
      case (in_word.operation)
        OP_START: begin
          we = 1'b1;
        end
        OP_APPEND: begin
          we    = (count < MAX_CNT);
          waddr = count[IDX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (uc.rd_first) begin
      re = 1'b1;
    end else if (uc.rd_loop && idx_lt) begin
      re    = 1'b1;
      raddr = idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {in_word.coord_x, in_word.coord_y};
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Edge assembly: the closing edge runs from the last vertex back to the first.
  always_comb begin
    if (uc.inject) begin
      cur_x = first_x;
      cur_y = first_y;
    end else begin
      cur_x = rdata[VW-1:COORD_W];
      cur_y = rdata[COORD_W-1:0];
    end
    edge_v = (rv && !rfirst) || uc.inject;
  end

  assign cross_prod = XW'(cp1) - XW'(cp2);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      rv        <= 1'b0;
      rfirst    <= 1'b0;
      bv        <= 1'b0;
      cv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pc     <= pc_next;
      rv     <= re;
      rfirst <= uc.rd_first;
      bv     <= edge_v;
      cv     <= bv;

      if (accept) begin
        case (in_word.operation)
          OP_START: begin
            count <= CNT_W'(1);
            ovf   <= 1'b0;
          end
          OP_APPEND: begin
            if (count < MAX_CNT) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if (uc.rd_first) begin
        idx <= CNT_W'(1);
      end else if (uc.rd_loop && idx_lt) begin
        idx <= idx + CNT_W'(1);
      end

      if (uc.result && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (acc_query) begin
      px  <= in_word.coord_x;
      py  <= in_word.coord_y;
      acc <= '0;
    end

    if (rv && rfirst) begin
      first_x <= cur_x;
      first_y <= cur_y;
    end
    if (rv) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end

    // stage one: differences and crossing direction
    ba  <= DW'(cur_x) - DW'(prev_x);
    bb  <= DW'(py) - DW'(prev_y);
    bc  <= DW'(cur_y) - DW'(prev_y);
    bd  <= DW'(px) - DW'(prev_x);
    bup <= (prev_y <= py) && (cur_y > py);
    bdn <= (prev_y > py) && (cur_y <= py);

    // stage two: the two products of the cross product
    cp1 <= PW'(ba) * PW'(bb);
    cp2 <= PW'(bc) * PW'(bd);
    cup <= bup;
    cdn <= bdn;

    // stage three: sign of the cross product decides the count
    if (cv) begin
      if (cup && (cross_prod > 0)) begin
        acc <= acc + WIND_W'(1);
      end else if (cdn && (cross_prod < 0)) begin
        acc <= acc - WIND_W'(1);
      end
    end

    if (uc.result && !out_busy) begin
      out_word.winding    <= acc;
      out_word.inside_res <= (acc != '0);
      out_word.overflowed <= ovf;
    end
  end

endmodule

`default_nettype wire

>>> sim/point_in_polygon_winding_tb.sv
`timescale 1ns / 1ps

module point_in_polygon_winding_tb;
  import pipw_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         DRAIN_CYCLES = MAX_VERTICES + 40;
  localparam int         HALF_PERIOD  = 10;
  localparam int         RESET_CYCLES = 9;

  // Coordinate styles for random polygons and query points.
  localparam int MODE_GRID    = 0;
  localparam int MODE_FULL    = 1;
  localparam int MODE_EXTREME = 2;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          failed = 1'b0;

  // Software copy of the polygon store.
  logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
  int unsigned               poly_len = 0;
  bit                        poly_dropped = 1'b0;
  out_word_t                 pending_results [$];

  point_in_polygon_winding dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  function automatic int winding_around(logic signed [COORD_W-1:0] px,
                                        logic signed [COORD_W-1:0] py);
    longint x0, y0, x1, y1, cross_prod;
    int     w;
    int     j;
    w = 0;
    for (int i = 0; i < poly_len; i++) begin
      j  = (i + 1 < poly_len) ? i + 1 : 0;
      x0 = poly_x[i];
      y0 = poly_y[i];
      x1 = poly_x[j];
      y1 = poly_y[j];
      cross_prod = (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
      if (y0 <= py && y1 > py) begin
        if (cross_prod > 0) w++;
      end else if (y0 > py && y1 <= py) begin
        if (cross_prod < 0) w--;
      end
    end
    return w;
  endfunction

  task automatic store_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    if (poly_len >= MAX_VERTICES) begin
      poly_dropped = 1'b1;
    end else begin
      poly_x[poly_len] = x;
      poly_y[poly_len] = y;
      poly_len++;
    end
  endtask

  // Applies one accepted word to the polygon copy and queues any result.
  task automatic track_polygon(in_word_t w);
    out_word_t r;
    int        wn;
    case (w.operation)
      OP_START: begin
        poly_len     = 0;
        poly_dropped = 1'b0;
        store_vertex(w.coord_x, w.coord_y);
      end
      OP_APPEND: store_vertex(w.coord_x, w.coord_y);
      OP_QUERY: begin
        wn           = winding_around(w.coord_x, w.coord_y);
        r.winding    = wn[WIND_W-1:0];
        r.inside_res = (wn != 0);
        r.overflowed = poly_dropped;
        pending_results = {pending_results, r};
      end
      default: ;
    endcase
  endtask

  task automatic send_word(logic [1:0] op, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y);
    in_word_t w;
    w.operation = op;
    w.coord_x   = x;
    w.coord_y   = y;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_polygon(w);
  endtask

  // Every result word is checked against the oldest expectation.
  always @(posedge clk) begin
    out_word_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: %p", out_word);
          failed = 1'b1;
        end else begin
          due = pending_results.pop_front();
          if (out_word.winding !== due.winding) begin
            $error("winding: expected %0d, got %0d", due.winding, out_word.winding);
            failed = 1'b1;
          end
          if (out_word.inside_res !== due.inside_res) begin
            $error("inside_res: expected %0b, got %0b", due.inside_res, out_word.inside_res);
            failed = 1'b1;
          end
          if (out_word.overflowed !== due.overflowed) begin
            $error("overflowed: expected %0b, got %0b", due.overflowed, out_word.overflowed);
            failed = 1'b1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
    int v;
    case (mode)
      MODE_GRID: v = int'($urandom_range(12)) - 6;
      MODE_EXTREME: begin
        case ($urandom_range(6))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = 32766;
          default: v = 32767;
        endcase
      end
      default: v = int'($urandom());
    endcase
    return v[COORD_W-1:0];
  endfunction

  task automatic send_polygon(int unsigned n, int mode);
    for (int unsigned k = 0; k < n; k++)
      send_word(k == 0 ? OP_START : OP_APPEND, rand_coord(mode), rand_coord(mode));
  endtask

  // Queries land on a stored vertex now and then, where the edge rules matter.
  task automatic send_query(int mode);
    int unsigned k;
    if (poly_len != 0 && $urandom_range(3) == 0) begin
      k = $urandom_range(poly_len - 1);
      send_word(OP_QUERY, poly_x[k], poly_y[k]);
    end else begin
      send_word(OP_QUERY, rand_coord(mode), rand_coord(mode));
    end
  endtask

  // A star polygon that turns around the origin the given number of times.
  task automatic send_star(int turns, int unsigned n);
    real                       a;
    logic signed [COORD_W-1:0] x, y;
    for (int unsigned k = 0; k < n; k++) begin
      a = 6.283185307179586 * turns * k / n;
      x = COORD_W'($rtoi(30000.0 * $cos(a)));
      y = COORD_W'($rtoi(30000.0 * $sin(a)));
      send_word(k == 0 ? OP_START : OP_APPEND, x, y);
    end
  endtask

  task automatic test_empty_and_orphan();
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_word(OP_APPEND, 16'sd5, -16'sd3);
    send_word(OP_QUERY, 16'sd5, -16'sd3);
    send_word(OP_UNUSED, 16'h7fff, 16'h8000);
    send_word(OP_QUERY, 16'sd4, -16'sd4);
  endtask

  task automatic test_corner_square();
    send_word(OP_START, 16'h8000, 16'h8000);
    send_word(OP_APPEND, 16'h7fff, 16'h8000);
    send_word(OP_APPEND, 16'h7fff, 16'h7fff);
    send_word(OP_APPEND, 16'h8000, 16'h7fff);
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_word(OP_QUERY, 16'h8000, 16'h8000);
    send_word(OP_QUERY, 16'h7fff, 16'h7fff);
    send_word(OP_QUERY, 16'h7fff, 16'sd0);
    // Same square walked clockwise.
    send_word(OP_START, 16'h8000, 16'h8000);
    send_word(OP_APPEND, 16'h8000, 16'h7fff);
    send_word(OP_APPEND, 16'h7fff, 16'h7fff);
    send_word(OP_APPEND, 16'h7fff, 16'h8000);
    send_word(OP_QUERY, -16'sd1, 16'sd1);
    send_word(OP_QUERY, 16'h8000, 16'sd0);
    // A two-vertex polygon is a line walked there and back.
    send_word(OP_START, -16'sd100, -16'sd100);
    send_word(OP_APPEND, 16'sd100, 16'sd100);
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_word(OP_QUERY, -16'sd50, 16'sd0);
  endtask

  task automatic test_store_overflow();
    send_polygon(MAX_VERTICES, MODE_GRID);
    send_query(MODE_GRID);
    send_word(OP_APPEND, 16'sd1, 16'sd1);
    send_word(OP_APPEND, 16'h8000, 16'h7fff);
    send_query(MODE_GRID);
    send_word(OP_START, 16'sd0, 16'sd0);
    send_word(OP_APPEND, 16'sd8, 16'sd0);
    send_word(OP_APPEND, 16'sd0, 16'sd8);
    send_word(OP_QUERY, 16'sd2, 16'sd2);
  endtask

  task automatic test_multi_turn();
    send_star(31, MAX_VERTICES);
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_word(OP_QUERY, 16'sd7, -16'sd3);
    send_star(-31, MAX_VERTICES);
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_star(3, 7);
    send_word(OP_QUERY, 16'sd0, 16'sd0);
    send_word(OP_QUERY, 16'sd20000, 16'sd0);
  endtask

  // Mostly whole polygons followed by queries; a tenth is loose noise.
  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned sent, pick, len, nq;
    int          mode;
    logic [1:0]  op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(2);
      pick = $urandom_range(99);
      if (pick < 90) begin
        if (pick < 3) len = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 6);
        else if (pick < 10) len = $urandom_range(9, MAX_VERTICES);
        else if (pick < 18) len = $urandom_range(1, 2);
        else len = $urandom_range(3, 8);
        send_polygon(len, mode);
        nq = $urandom_range(1, 6);
        repeat (nq) send_query(mode);
        sent += len + nq;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          op = 2'($urandom_range(3));
          send_word(op, rand_coord(mode), rand_coord(mode));
          if (op != OP_UNUSED) sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_orphan();
    test_corner_square();
    test_store_overflow();
    test_multi_turn();
    test_random_traffic(280, 0, 0);
    test_random_traffic(280, 83, 0);
    test_random_traffic(280, 0, 83);
    test_random_traffic(280, 9, 9);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
